### rtl/core/conv2d_valid_3x3_defines.svh
// ---------------------------------------------------------------------------
// conv2d_valid_3x3 assertion macros
// concurrent check wrappers, empty when SYNTHESIS is set
// ---------------------------------------------------------------------------
`ifndef CONV2D_VALID_3X3_DEFINES_SVH
`define CONV2D_VALID_3X3_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define C2V3_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("conv2d_valid_3x3 check failed");
// next-cycle implication, checked out of reset
`define C2V3_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("conv2d_valid_3x3 check failed");
`else
`define C2V3_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define C2V3_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

### rtl/core/c2v3_pkg.sv
// ---------------------------------------------------------------------------
// c2v3_pkg
// constants, types and helpers of the 3x3 valid-region convolution
// ---------------------------------------------------------------------------
package c2v3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 3;
    localparam int KERNEL_SIZE = 3;
    localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIX_BITS    = 8;
    localparam int COEF_BITS   = 16;

    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int ENTRY_W     = 2 * PIX_BITS;
    localparam int KROW_W      = KERNEL_SIZE * COEF_BITS;
    localparam int FW_W        = 11;
    localparam int FH_W        = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = KROW_W;
    localparam int VALUE_W     = 32;

    // product of an unsigned pixel and a signed coefficient, then the sums
    localparam int PROD_W      = PIX_BITS + 1 + COEF_BITS;
    localparam int RSUM_W      = PROD_W + 2;
    localparam int SUM_W       = PROD_W + 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_TOP    = 3'd0,
        CFG_KERNEL_MIDDLE = 3'd1,
        CFG_KERNEL_BOTTOM = 3'd2,
        CFG_FRAME_WIDTH   = 3'd3,
        CFG_FRAME_HEIGHT  = 3'd4
    } t_cfg_idx;

    typedef logic [PIX_BITS-1:0]        t_pix;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [RSUM_W-1:0]   t_rsum;

    // result tag that travels along the pipeline
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] col;
        logic              last;
    } t_tag;

    // coefficient k of one packed kernel row, left one in the low bits
    function automatic logic signed [COEF_BITS-1:0] coef_of(
        input logic [KROW_W-1:0] row_bits,
        input int unsigned       k
    );
        return row_bits[COEF_BITS*k +: COEF_BITS];
    endfunction

endpackage

### rtl/core/conv2d_valid_3x3.sv
// an input transaction reaches its result transaction through the stage 1, product, row-sum and output registers
// throughput: one pixel per cycle while the output does not stall, set by the single line
//   memory doing one read at accept and one write-back as the item leaves stage 1, at different columns
// border pixels give no result transaction
// reset (synchronous, active low) clears counters, window and pipeline valids,
//   zeroes the kernel and sets the frame size to 640x480; the line memory is not cleared
// ---------------------------------------------------------------------------
// conv2d_valid_3x3
// streaming 3x3 convolution over the valid region of a raster frame
// ---------------------------------------------------------------------------
`include "conv2d_valid_3x3_defines.svh"

module conv2d_valid_3x3 (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [c2v3_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [c2v3_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [c2v3_pkg::PIX_BITS-1:0]        i_pixel,
    // result output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [c2v3_pkg::VALUE_W-1:0]  o_conv_value,
    output logic [c2v3_pkg::ROW_W-1:0]           o_centre_row,
    output logic [c2v3_pkg::ADDR_W-1:0]          o_centre_col,
    output logic                                 o_frame_last
);
    import c2v3_pkg::*;

    // configuration registers
    logic [KROW_W-1:0] r_krow [KERNEL_SIZE];
    logic [FW_W-1:0]   r_frame_w;
    logic [FH_W-1:0]   r_frame_h;

    // clamped frame size
    logic [FW_W-1:0] w_width;
    logic [FH_W-1:0] w_height;

    // position of the next pixel
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;

    // line memory: low byte is the line above, high byte two lines above
    logic [ENTRY_W-1:0] r_mem [MAX_WIDTH];
    logic [ENTRY_W-1:0] r_mem_rdata;

    // 3x3 window, row-major, left column oldest
    t_pix r_win [KERNEL_TAPS];
    t_pix n_win [KERNEL_TAPS];

    // stage 1: memory data arrives, window update and write-back
    logic              r_v1;
    logic [ADDR_W-1:0] r_s1_col;
    logic              r_s1_emit;
    t_tag              r_s1_tag;
    t_pix              r_s1_px;

    // stage 2: products
    logic  r_v2;
    t_tag  r_s2_tag;
    t_prod r_prod [KERNEL_TAPS];
    t_prod n_prod [KERNEL_TAPS];

    // stage 3: row sums
    logic  r_v3;
    t_tag  r_s3_tag;
    t_rsum r_rsum [KERNEL_SIZE];

    // output register
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    t_tag                       r_out_tag;

    // handshake and stage enables, each stage moves when its successor frees up
    logic w_en_out, w_en3, w_en2, w_en1, w_in_acc;
    logic w_col_wrap, w_row_wrap, w_emit;
    logic signed [COEF_BITS-1:0] w_coef [KERNEL_TAPS];

    assign w_en_out = !r_out_valid || !i_out_stall;
    assign w_en3    = !r_v3 || w_en_out;
    assign w_en2    = !r_v2 || w_en3;
    assign w_en1    = !r_v1 || w_en2;
    assign w_in_acc = i_in_valid && w_en1;

    assign o_in_stall = !w_en1;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                r_krow[k] <= '0;
            end
            r_frame_w <= FW_W'(640);
            r_frame_h <= FH_W'(480);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KERNEL_TOP:    r_krow[0] <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: r_krow[1] <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: r_krow[2] <= i_cfg_data[KROW_W-1:0];
                CFG_FRAME_WIDTH:   r_frame_w <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT:  r_frame_h <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range sizes act as the nearest legal size
    always_comb begin
        if (r_frame_w < FW_W'(MIN_DIM)) begin
            w_width = FW_W'(MIN_DIM);
        end else if (r_frame_w > FW_W'(MAX_WIDTH)) begin
            w_width = FW_W'(MAX_WIDTH);
        end else begin
            w_width = r_frame_w;
        end
        if (r_frame_h < FH_W'(MIN_DIM)) begin
            w_height = FH_W'(MIN_DIM);
        end else if (r_frame_h > FH_W'(MAX_HEIGHT)) begin
            w_height = FH_W'(MAX_HEIGHT);
        end else begin
            w_height = r_frame_h;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: position counters and memory read at accept
    // ------------------------------------------------------------------
    assign w_col_wrap = (FW_W'(r_col) + FW_W'(1)) >= w_width;
    assign w_row_wrap = (FH_W'(r_row) + FH_W'(1)) >= w_height;
    assign w_emit     = (r_row >= ROW_W'(2)) && (r_col >= ADDR_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_acc) begin
            if (w_col_wrap) begin
                r_col <= '0;
                r_row <= w_row_wrap ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    // read at accept, write-back when the item leaves stage 1; the write column is the one
    // just before the read column, or the line end when the read wraps to column 0, so no bypass
    always_ff @(posedge i_clk) begin
        if (r_v1 && w_en2) begin
            r_mem[r_s1_col] <= {r_mem_rdata[PIX_BITS-1:0], r_s1_px};
        end
        if (w_in_acc) begin
            r_mem_rdata <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_col       <= r_col;
            r_s1_px        <= i_pixel;
            r_s1_emit      <= w_emit;
            r_s1_tag.row   <= r_row - ROW_W'(1);
            r_s1_tag.col   <= r_col - ADDR_W'(1);
            r_s1_tag.last  <= w_col_wrap && w_row_wrap;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: window shift and the nine products
    // ------------------------------------------------------------------
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
                n_win[r*KERNEL_SIZE + c] = r_win[r*KERNEL_SIZE + c + 1];
            end
        end
        n_win[KERNEL_SIZE-1]           = r_mem_rdata[ENTRY_W-1:PIX_BITS];
        n_win[2*KERNEL_SIZE-1]         = r_mem_rdata[PIX_BITS-1:0];
        n_win[KERNEL_TAPS-1]           = r_s1_px;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE; c++) begin
                w_coef[r*KERNEL_SIZE + c] = coef_of(r_krow[r], c);
            end
        end
        for (int i = 0; i < KERNEL_TAPS; i++) begin
            n_prod[i] = $signed({1'b0, n_win[i]}) * w_coef[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KERNEL_TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_v1 && w_en2) begin
            for (int i = 0; i < KERNEL_TAPS; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // only items that complete a full window go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1 && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && w_en2) begin
            r_s2_tag <= r_s1_tag;
            for (int i = 0; i < KERNEL_TAPS; i++) begin
                r_prod[i] <= n_prod[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: row sums
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_en3) begin
            r_s3_tag <= r_s2_tag;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                r_rsum[r] <= RSUM_W'(r_prod[r*KERNEL_SIZE])
                           + RSUM_W'(r_prod[r*KERNEL_SIZE + 1])
                           + RSUM_W'(r_prod[r*KERNEL_SIZE + 2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: final sum into the output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_en_out) begin
            r_out_tag   <= r_s3_tag;
            r_out_value <= VALUE_W'(SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1])
                                    + SUM_W'(r_rsum[2]));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_conv_value = r_out_value;
    assign o_centre_row = r_out_tag.row;
    assign o_centre_col = r_out_tag.col;
    assign o_frame_last = r_out_tag.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // column steps by one or wraps to the line start on every transaction
    `C2V3_ASSERT_NEXT(a_col_step, i_clk, i_rst_n, w_in_acc, (r_col == $past(r_col) + ADDR_W'(1)) || (r_col == '0))
    // a write-back never hits the column read in the same cycle
    `C2V3_ASSERT_SAME(a_no_rw_clash, i_clk, i_rst_n, r_v1 && w_en2 && w_in_acc, r_s1_col != r_col)
    // a result never sits on the top row or the left column
    `C2V3_ASSERT_SAME(a_no_border, i_clk, i_rst_n, r_out_valid, (r_out_tag.row != '0) && (r_out_tag.col != '0))

endmodule
